[src/gda_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and calendar tables for the Gregorian date core.
// Used by gda_year_unit and gregorian_date_arithmetic_core; no dependencies.
package gda_pkg;

	// Supported calendar range
	localparam int BASE_YEAR = 1900;
	localparam int MAX_YEAR  = 9999;

	// Field widths
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int OFS_W   = 23;
	localparam int SER_W   = 22;
	localparam int YD_W    = 9;
	localparam int WD_W    = 3;
	localparam int SUM_W   = SER_W + 2;

	// Year search covers BASE_YEAR + k, k one bit per step
	localparam int K_W = $clog2(MAX_YEAR - BASE_YEAR + 1);

	// y / 100 as (y * 5243) >> 19, exact for y below 43690
	localparam int DIV100_MULT  = 5243;
	localparam int DIV100_SHIFT = 19;
	localparam int PROD_W       = YEAR_W + 13;
	localparam int Q100_W       = PROD_W - DIV100_SHIFT;
	localparam int DAYS_YEAR    = 365;

	// Packed stream widths
	localparam int IN_W  = 72;
	localparam int OUT_W = 64;

	function automatic int leaps_upto(input int n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	function automatic int days_before(input int y);
		return DAYS_YEAR * (y - BASE_YEAR) + leaps_upto(y - 1) - leaps_upto(BASE_YEAR - 1);
	endfunction

	// Weekday of 1 January of year y, 0 is Sunday
	function automatic int jan1_weekday(input int y);
		int yy;
		yy = y - 1;
		return (23 / 9 + 1 + y + 4 + yy / 4 - yy / 100 + yy / 400) % 7;
	endfunction

	localparam int LEAPS_BASE = leaps_upto(BASE_YEAR - 1);
	localparam int DB_END     = days_before(MAX_YEAR + 1);
	// Added to the serial day so that serial 1 lands on the weekday of 1 January BASE_YEAR
	localparam int WD_ADJ     = (jan1_weekday(BASE_YEAR) + 6) % 7;

	// Request to and answer from the shared year unit
	typedef struct packed {
		logic              start;
		logic [YEAR_W-1:0] year;
	} yu_req_t;

	typedef struct packed {
		logic             done;
		logic             leap;
		logic [SER_W-1:0] db;
	} yu_resp_t;

	// Input item, first field in the lowest bits
	typedef struct packed {
		logic [2:0]               pad;
		logic signed [OFS_W-1:0]  day_offset;
		logic [YEAR_W-1:0]        b_year;
		logic [MONTH_W-1:0]       b_month;
		logic [DAY_W-1:0]         b_day;
		logic [YEAR_W-1:0]        a_year;
		logic [MONTH_W-1:0]       a_month;
		logic [DAY_W-1:0]         a_day;
	} in_item_t;

	// Result item, first field in the lowest bits
	typedef struct packed {
		logic [3:0]         pad;
		logic               sum_valid;
		logic [YEAR_W-1:0]  sum_year;
		logic [MONTH_W-1:0] sum_month;
		logic [DAY_W-1:0]   sum_day;
		logic [SER_W-1:0]   day_diff;
		logic [YD_W-1:0]    year_day;
		logic [WD_W-1:0]    week_day;
		logic               b_valid;
		logic               a_valid;
	} out_item_t;

	// Length of month m
	function automatic logic [DAY_W-1:0] month_len(input logic leap, input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days of the year that lie before the first of month m
	function automatic logic [YD_W-1:0] cum_days(input logic leap, input logic [MONTH_W-1:0] m);
		logic [YD_W-1:0] base;
		unique case (m)
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + YD_W'(leap && (m >= 4'd3));
	endfunction

	function automatic logic date_ok(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
			input logic [YEAR_W-1:0] y, input logic leap);
		return (y >= YEAR_W'(BASE_YEAR)) && (y <= YEAR_W'(MAX_YEAR)) &&
			(m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) && (d <= month_len(leap, m));
	endfunction

	// Residue mod 7 by folding octal digits (8 is 1 mod 7)
	function automatic logic [WD_W-1:0] mod7(input logic [SUM_W-1:0] v);
		logic [5:0] s;
		logic [3:0] f;
		logic [3:0] g;
		s = '0;
		for (int i = 0; i < SUM_W / 3; i++) begin
			s = s + 6'(v[3*i +: 3]);
		end
		f = 4'(s[2:0]) + 4'(s[5:3]);
		g = 4'(f[2:0]) + 4'(f[3]);
		return (g >= 4'd7) ? 3'(g - 4'd7) : g[2:0];
	endfunction

endpackage

[src/gda_year_unit.sv]
`timescale 1ns / 1ps
// Shared year unit: serial days before 1 January of a year, and its leap flag.
// Two-stage pipeline; depends on gda_pkg.
module gda_year_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  gda_pkg::yu_req_t  req,
	output gda_pkg::yu_resp_t resp
);
	import gda_pkg::*;

	logic                v_s1, v_s2;
	logic [YEAR_W-1:0]   y_s1;
	logic [Q100_W-1:0]   q100_s1;
	logic                leap_s2;
	logic [SER_W-1:0]    db_s2;

	logic [PROD_W-1:0]   prod;
	logic [YEAR_W-1:0]   hundreds;
	logic                leap_c;
	logic [SUM_W-1:0]    lu;
	logic [SUM_W-1:0]    db_c;

	// Stage 1: y / 100 by reciprocal multiply
	assign prod = PROD_W'(req.year) * PROD_W'(DIV100_MULT);

	// Stage 2: leap test and day count
	always_comb begin
		hundreds = YEAR_W'(q100_s1) * YEAR_W'(100);
		leap_c   = (y_s1[1:0] == 2'b00) && ((y_s1 != hundreds) || (q100_s1[1:0] == 2'b00));
		// leaps in 1..y
		lu       = SUM_W'(y_s1[YEAR_W-1:2]) - SUM_W'(q100_s1) + SUM_W'(q100_s1[Q100_W-1:2]);
		db_c     = (SUM_W'(y_s1) - SUM_W'(BASE_YEAR)) * SUM_W'(DAYS_YEAR) + lu
			- SUM_W'(leap_c) - SUM_W'(LEAPS_BASE);
	end

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
		end
	end

	// Data pipeline
	always_ff @(posedge clk) begin
		y_s1    <= req.year;
		q100_s1 <= prod[PROD_W-1:DIV100_SHIFT];
		leap_s2 <= leap_c;
		db_s2   <= db_c[SER_W-1:0];
	end

	assign resp.done = v_s2;
	assign resp.leap = leap_s2;
	assign resp.db   = db_s2;

endmodule

[src/gregorian_date_arithmetic_core.sv]
`timescale 1ns / 1ps
// Gregorian date core: validity, weekday, day of year, date shift and day difference.
// Depends on gda_pkg and gda_year_unit.
//
// Each input item carries dates A and B and a signed day offset; one result item
// comes back per input item. The block handles one item at a time and drops
// s_tready while it works. All calendar arithmetic goes through one shared year
// unit (days before 1 January of a year plus leap flag) under a small sequencer:
// date A, date B, then a 13-step bitwise search for the year of the shifted date
// and one more use for that year, followed by a month and a day step. The search
// and the steps after it run only for a valid A with an in-range shift; otherwise
// the result follows the range check directly. The block is ready again as soon
// as the result is loaded. The result sits in an output register, so the next
// item is accepted while it waits on m_tready.
module gregorian_date_arithmetic_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// a_day, a_month, a_year, b_day, b_month, b_year, day_offset, zero pad
	input  logic [gda_pkg::IN_W-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// a_valid, b_valid, week_day, year_day, day_diff, sum_day, sum_month,
	// sum_year, sum_valid, zero pad
	output logic [gda_pkg::OUT_W-1:0] m_tdata
);
	import gda_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_A_REQ, ST_A_WAIT, ST_B_REQ, ST_B_WAIT, ST_RANGE,
		ST_S_REQ, ST_S_WAIT, ST_Y_REQ, ST_Y_WAIT, ST_MONTH, ST_DAY, ST_DONE
	} state_t;

	state_t                  state_q;
	in_item_t                in_c;
	in_item_t                item_q;
	yu_req_t                 req;
	yu_resp_t                resp;
	out_item_t               work_q;
	out_item_t               out_q;
	logic                    out_valid_q;
	logic                    out_load;

	logic [SER_W-1:0]        ta_q;
	logic [SER_W-1:0]        t_q;
	logic [K_W-1:0]          k_q;
	logic [K_W-1:0]          bit_q;
	logic [YD_W-1:0]         rem_q;
	logic                    leap_s_q;

	logic [K_W-1:0]          trial;
	logic                    a_ok, b_ok;
	logic [YD_W-1:0]         ord_a, ord_b;
	logic [SER_W-1:0]        tb;
	logic signed [SUM_W-1:0] t_sum;
	logic                    t_ok;
	logic [MONTH_W-1:0]      mcount;

	assign in_c     = in_item_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	gda_year_unit u_year (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.resp   (resp)
	);

	// Year unit request
	always_comb begin
		trial     = k_q | bit_q;
		req.start = (state_q == ST_A_REQ) || (state_q == ST_B_REQ) ||
			(state_q == ST_S_REQ) || (state_q == ST_Y_REQ);
		unique case (state_q)
			ST_A_REQ: req.year = item_q.a_year;
			ST_B_REQ: req.year = item_q.b_year;
			ST_S_REQ: req.year = YEAR_W'(BASE_YEAR) + YEAR_W'(trial);
			ST_Y_REQ: req.year = YEAR_W'(BASE_YEAR) + YEAR_W'(k_q);
			default:  req.year = '0;
		endcase
	end

	// Date checks, ordinals and shift range
	always_comb begin
		a_ok  = date_ok(item_q.a_day, item_q.a_month, item_q.a_year, resp.leap);
		b_ok  = date_ok(item_q.b_day, item_q.b_month, item_q.b_year, resp.leap);
		ord_a = cum_days(resp.leap, item_q.a_month) + YD_W'(item_q.a_day);
		ord_b = cum_days(resp.leap, item_q.b_month) + YD_W'(item_q.b_day);
		tb    = resp.db + SER_W'(ord_b);
		t_sum = $signed({2'b00, ta_q}) + $signed({item_q.day_offset[OFS_W-1], item_q.day_offset});
		t_ok  = work_q.a_valid && (t_sum > $signed(SUM_W'(0))) &&
			(t_sum <= $signed(SUM_W'(DB_END)));
	end

	// Month of the remaining day of year
	always_comb begin
		mcount = 4'd1;
		for (int j = 1; j < 12; j++) begin
			if (rem_q > cum_days(leap_s_q, MONTH_W'(j + 1))) begin
				mcount = mcount + 4'd1;
			end
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			work_q      <= '0;
			item_q      <= '0;
			ta_q        <= '0;
			t_q         <= '0;
			k_q         <= '0;
			bit_q       <= '0;
			rem_q       <= '0;
			leap_s_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						item_q  <= in_c;
						work_q  <= '0;
						state_q <= ST_A_REQ;
					end
				end
				ST_A_REQ: state_q <= ST_A_WAIT;
				ST_A_WAIT: begin
					if (resp.done) begin
						work_q.a_valid  <= a_ok;
						work_q.year_day <= a_ok ? ord_a : '0;
						ta_q            <= resp.db + SER_W'(ord_a);
						state_q         <= ST_B_REQ;
					end
				end
				ST_B_REQ: state_q <= ST_B_WAIT;
				ST_B_WAIT: begin
					if (resp.done) begin
						work_q.b_valid <= b_ok;
						if (work_q.a_valid && b_ok) begin
							work_q.day_diff <= (ta_q > tb) ? ta_q - tb : tb - ta_q;
						end
						state_q <= ST_RANGE;
					end
				end
				ST_RANGE: begin
					if (work_q.a_valid) begin
						work_q.week_day <= mod7(SUM_W'(ta_q) + SUM_W'(WD_ADJ));
					end
					if (t_ok) begin
						work_q.sum_valid <= 1'b1;
						t_q     <= t_sum[SER_W-1:0];
						k_q     <= '0;
						bit_q   <= {1'b1, {(K_W-1){1'b0}}};
						state_q <= ST_S_REQ;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_S_REQ: state_q <= ST_S_WAIT;
				ST_S_WAIT: begin
					// keep the trial bit while the year still starts before t
					if (resp.done) begin
						if (resp.db < t_q) begin
							k_q <= trial;
						end
						bit_q   <= bit_q >> 1;
						state_q <= bit_q[0] ? ST_Y_REQ : ST_S_REQ;
					end
				end
				ST_Y_REQ: state_q <= ST_Y_WAIT;
				ST_Y_WAIT: begin
					if (resp.done) begin
						rem_q           <= YD_W'(t_q - resp.db);
						leap_s_q        <= resp.leap;
						work_q.sum_year <= YEAR_W'(BASE_YEAR) + YEAR_W'(k_q);
						state_q         <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					work_q.sum_month <= mcount;
					state_q          <= ST_DAY;
				end
				ST_DAY: begin
					work_q.sum_day <= DAY_W'(rem_q - cum_days(leap_s_q, work_q.sum_month));
					state_q        <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_q   <= work_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Year unit answers only while the sequencer waits for it
	ap_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		resp.done |-> (state_q == ST_A_WAIT || state_q == ST_B_WAIT ||
			state_q == ST_S_WAIT || state_q == ST_Y_WAIT))
		else $error("year unit answer outside a wait state");

	// One request at a time
	ap_single_issue: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> !req.start)
		else $error("year unit issued twice in a row");

	// Search keeps exactly one trial bit
	ap_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_S_REQ || state_q == ST_S_WAIT) |-> $onehot(bit_q))
		else $error("search bit not one-hot");

	// Day left in the found year is a real ordinal
	ap_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MONTH) |-> (rem_q >= 9'd1 && rem_q <= 9'd366))
		else $error("remaining day out of year");

	// A shifted date comes only from a valid A and stays in the year range
	ap_sum_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.sum_valid) |-> (out_q.a_valid &&
			out_q.sum_year >= YEAR_W'(BASE_YEAR) && out_q.sum_year <= YEAR_W'(MAX_YEAR)))
		else $error("shifted date inconsistent");

endmodule

[tb/gregorian_date_arithmetic_core_tb.sv]
`timescale 1ns / 1ps
// Testbench for gregorian_date_arithmetic_core: stream stimulus, a calendar predictor
// and an in-order result checker. Depends on gda_pkg and the core RTL.
module gregorian_date_arithmetic_core_tb;

	import gda_pkg::in_item_t;
	import gda_pkg::out_item_t;
	import gda_pkg::BASE_YEAR;
	import gda_pkg::MAX_YEAR;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 100;

	// Date as it travels in one half of an input item
	typedef struct packed {
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
	} date_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// a_day, a_month, a_year, b_day, b_month, b_year, day_offset, zero pad
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// a_valid, b_valid, week_day, year_day, day_diff, sum_day, sum_month,
	// sum_year, sum_valid, zero pad
	logic [63:0] m_tdata;

	out_item_t   expected_dates[$];
	int          errors = 0;
	int          n_sent = 0;
	int          n_checked = 0;
	int          cycle_cnt = 0;
	bit          no_idle = 1'b0;
	int          hold_reqs = 0;
	int          hold_seen = 0;
	int          hold_cnt = 0;
	int          ready_wait = 0;
	out_item_t   got_item;
	out_item_t   want_item;

	gregorian_date_arithmetic_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ---------------- calendar predictor ----------------

	function automatic bit leap_yr(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int mdays(input bit lp, input int m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return lp ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// Leap years among 1..n
	function automatic int leap_count(input int n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	// Serial days before 1 January of year y; 1 January of the base year is serial 1
	function automatic int days_ahead_of(input int y);
		return 365 * (y - BASE_YEAR) + leap_count(y - 1) - leap_count(BASE_YEAR - 1);
	endfunction

	function automatic int last_serial();
		return days_ahead_of(MAX_YEAR + 1);
	endfunction

	function automatic bit valid_date(input date_t dt_in);
		int y;
		int m;
		int d;
		y = dt_in.y;
		m = dt_in.m;
		d = dt_in.d;
		if (y < BASE_YEAR || y > MAX_YEAR || m < 1 || m > 12 || d < 1)
			return 1'b0;
		return d <= mdays(leap_yr(y), m);
	endfunction

	function automatic int day_of_year(input date_t dt_in);
		int s;
		s = dt_in.d;
		for (int i = 1; i < dt_in.m; i++)
			s += mdays(leap_yr(dt_in.y), i);
		return s;
	endfunction

	function automatic int serial_of(input date_t dt_in);
		return day_of_year(dt_in) + days_ahead_of(dt_in.y);
	endfunction

	function automatic out_item_t calc_dates(input in_item_t it);
		out_item_t r;
		date_t     a;
		date_t     b;
		int        sa;
		int        sb;
		int        t;
		int        y;
		int        m;
		int        off;
		r = '0;
		a = '{y: it.a_year, m: it.a_month, d: it.a_day};
		b = '{y: it.b_year, m: it.b_month, d: it.b_day};
		off = int'($signed(it.day_offset));
		r.a_valid = valid_date(a);
		r.b_valid = valid_date(b);
		if (r.a_valid) begin
			sa = serial_of(a);
			// serial 1 is a Monday, so the residue is the weekday directly
			r.week_day = 3'(sa % 7);
			r.year_day = 9'(day_of_year(a));
			if (r.b_valid) begin
				sb = serial_of(b);
				r.day_diff = 22'((sa > sb) ? sa - sb : sb - sa);
			end
			t = sa + off;
			if (t >= 1 && t <= last_serial()) begin
				y = BASE_YEAR + (t - 1) / 366;
				while (days_ahead_of(y + 1) < t)
					y++;
				t -= days_ahead_of(y);
				m = 1;
				while (m < 12 && t > mdays(leap_yr(y), m)) begin
					t -= mdays(leap_yr(y), m);
					m++;
				end
				r.sum_day = 5'(t);
				r.sum_month = 4'(m);
				r.sum_year = 14'(y);
				r.sum_valid = 1'b1;
			end
		end
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic date_t dt(input int d, input int m, input int y);
		return '{y: 14'(y), m: 4'(m), d: 5'(d)};
	endfunction

	function automatic in_item_t mk_item(input date_t a, input date_t b, input int off);
		in_item_t it;
		it = '0;
		it.a_day = a.d;
		it.a_month = a.m;
		it.a_year = a.y;
		it.b_day = b.d;
		it.b_month = b.m;
		it.b_year = b.y;
		it.day_offset = off[22:0];
		return it;
	endfunction

	// Valid date, biased toward the range ends, leap years and month ends
	function automatic date_t rand_valid_date();
		int y;
		int m;
		int d;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			y = $urandom_range(BASE_YEAR, BASE_YEAR + 5);
		else if (sel == 1)
			y = $urandom_range(MAX_YEAR - 5, MAX_YEAR);
		else if (sel == 2)
			y = 4 * $urandom_range(BASE_YEAR / 4, MAX_YEAR / 4);
		else
			y = $urandom_range(BASE_YEAR, MAX_YEAR);
		m = $urandom_range(1, 12);
		if ($urandom_range(0, 3) == 0)
			d = mdays(leap_yr(y), m);
		else
			d = $urandom_range(1, mdays(leap_yr(y), m));
		return dt(d, m, y);
	endfunction

	// Any field values at all, years mostly near the lower bound
	function automatic date_t rand_raw_date();
		int y;
		if ($urandom_range(0, 1) == 0)
			y = $urandom_range(0, MAX_YEAR);
		else
			y = $urandom_range(BASE_YEAR - 5, BASE_YEAR + 5);
		return dt($urandom_range(0, 31), $urandom_range(0, 15), y);
	endfunction

	function automatic int rand_offset(input date_t a);
		int sel;
		int k;
		sel = $urandom_range(0, 7);
		k = int'($urandom_range(0, 4)) - 2;
		case (sel)
			0, 1, 2, 3: return int'($urandom_range(0, 2200)) - 1100;
			4, 5:       return int'($urandom_range(0, 800000)) - 400000;
			6:          return int'($urandom_range(0, 8388607)) - 4194304;
			default: begin
				// land within a few days of either end of the calendar
				if (!valid_date(a))
					return k;
				if ($urandom_range(0, 1) == 0)
					return 1 + k - serial_of(a);
				return last_serial() + k - serial_of(a);
			end
		endcase
	endfunction

	// Offer one item after a random gap; returns at the accepting edge
	task automatic send_item(input in_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_sent++;
	endtask

	// ---------------- tests ----------------

	task automatic test_calendar_edges();
		send_item(mk_item(dt(1, 1, BASE_YEAR), dt(1, 1, BASE_YEAR), 0));
		send_item(mk_item(dt(31, 12, MAX_YEAR), dt(1, 1, BASE_YEAR), 0));
		send_item(mk_item(dt(29, 2, 2000), dt(1, 3, 2000), 1));
		send_item(mk_item(dt(29, 2, 2024), dt(28, 2, 2023), 366));
		send_item(mk_item(dt(31, 12, 2000), dt(31, 12, 1900), -366));
		send_item(mk_item(dt(31, 12, 1900), dt(1, 1, 1901), 1));
		send_item(mk_item(dt(1, 3, 2100), dt(28, 2, 2100), -1));
	endtask

	task automatic test_invalid_dates();
		send_item(mk_item(dt(29, 2, 1900), dt(1, 1, 2000), 10));
		send_item(mk_item(dt(29, 2, 2023), dt(1, 1, 2000), 10));
		send_item(mk_item(dt(0, 5, 2000), dt(1, 5, 2000), 0));
		send_item(mk_item(dt(10, 0, 2000), dt(1, 5, 2000), 0));
		send_item(mk_item(dt(10, 13, 2000), dt(1, 5, 2000), 0));
		send_item(mk_item(dt(31, 15, 9999), dt(31, 15, 9999), -1));
		send_item(mk_item(dt(31, 4, 2010), dt(30, 4, 2010), 0));
		send_item(mk_item(dt(31, 12, 1899), dt(1, 1, 1900), 1));
		send_item(mk_item(dt(1, 1, 0), dt(0, 0, 0), 0));
		// valid A with an invalid B only clears the difference
		send_item(mk_item(dt(15, 6, 2000), dt(31, 2, 2000), 100));
	endtask

	task automatic test_shift_bounds();
		date_t mid;
		mid = dt(15, 6, 5000);
		send_item(mk_item(dt(1, 1, BASE_YEAR), dt(1, 1, BASE_YEAR), -1));
		send_item(mk_item(dt(31, 12, MAX_YEAR), dt(31, 12, MAX_YEAR), 1));
		send_item(mk_item(mid, dt(1, 1, BASE_YEAR), -4194304));
		send_item(mk_item(mid, dt(31, 12, MAX_YEAR), 4194303));
		send_item(mk_item(mid, mid, 1 - serial_of(mid)));
		send_item(mk_item(mid, mid, last_serial() - serial_of(mid)));
		send_item(mk_item(mid, mid, last_serial() + 1 - serial_of(mid)));
	endtask

	task automatic test_random_mix(input int count);
		date_t a;
		date_t b;
		int    sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			a = (sel >= 85) ? rand_raw_date() : rand_valid_date();
			b = (sel >= 60 && sel < 80) ? rand_raw_date() : rand_valid_date();
			send_item(mk_item(a, b, rand_offset(a)));
		end
	endtask

	// Back-to-back items with both sides always ready
	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		test_random_mix(count);
		no_idle = 1'b0;
	endtask

	// Long output stall while the sender keeps offering items
	task automatic test_output_stall(input int count);
		no_idle = 1'b1;
		hold_reqs++;
		test_random_mix(count);
		no_idle = 1'b0;
	endtask

	// ---------------- receiver ----------------

	// Per-item random wait, or a long hold-off when asked
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else if (hold_reqs != hold_seen) begin
				hold_seen <= hold_seen + 1;
				hold_cnt <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				ready_wait = no_idle ? 0 : $urandom_range(0, 7);
				m_tready <= (ready_wait == 0);
				if (ready_wait > 0)
					ready_wait = ready_wait - 1;
			end else if (ready_wait > 0) begin
				ready_wait = ready_wait - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------- scoreboard ----------------

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Expected result for every accepted item
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			expected_dates.push_back(calc_dates(in_item_t'(s_tdata)));
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_item = out_item_t'(m_tdata);
			if (expected_dates.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				want_item = expected_dates.pop_front();
				check_field("a_valid", want_item.a_valid, got_item.a_valid);
				check_field("b_valid", want_item.b_valid, got_item.b_valid);
				check_field("week_day", want_item.week_day, got_item.week_day);
				check_field("year_day", want_item.year_day, got_item.year_day);
				check_field("day_diff", want_item.day_diff, got_item.day_diff);
				check_field("sum_day", want_item.sum_day, got_item.sum_day);
				check_field("sum_month", want_item.sum_month, got_item.sum_month);
				check_field("sum_year", want_item.sum_year, got_item.sum_year);
				check_field("sum_valid", want_item.sum_valid, got_item.sum_valid);
				n_checked++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_dates.size());
			$display("gregorian_date_arithmetic_core test failed");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_calendar_edges();
		test_invalid_dates();
		test_shift_bounds();
		test_random_mix(900);
		test_output_stall(12);
		test_back_to_back(150);
		test_random_mix(800);
		s_tvalid <= 1'b0;

		// drain, then let a late stray result show up
		while (expected_dates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items sent, %0d results checked", n_sent, n_checked);
		$display("covered calendar edges, invalid dates, shift bounds, random dates, bursts, stall");
		if (errors == 0)
			$display("gregorian_date_arithmetic_core test passed");
		else
			$display("gregorian_date_arithmetic_core test failed");
		$finish;
	end

endmodule

[sim.f]
src/gda_pkg.sv
src/gda_year_unit.sv
src/gregorian_date_arithmetic_core.sv
tb/gregorian_date_arithmetic_core_tb.sv
